[design/ldae_pkg.sv]
// Package for the log-companded DPCM audio encoder: the threshold and decode
// tables, the code lookup functions and the result struct of the codec.
// No dependencies; the codec and the top level import it.
`timescale 1ns / 1ps

package ldae_pkg;

   localparam int THR_COUNT = 84;
   localparam int DIRECT_LIMIT = 44;

   localparam logic [1:0] STEREO_CHANNELS = 2'd2;

   // Smallest magnitude that reaches each code from 44 upward.
   localparam logic [15:0] ENC_THR [0:THR_COUNT-1] = '{
      16'd46, 16'd50, 16'd55, 16'd60, 16'd65, 16'd71, 16'd77, 16'd84, 16'd92, 16'd100,
      16'd109, 16'd119, 16'd130, 16'd142, 16'd155, 16'd169, 16'd184, 16'd200, 16'd219,
      16'd238, 16'd260, 16'd284, 16'd309, 16'd337, 16'd368, 16'd401, 16'd438, 16'd477,
      16'd520, 16'd568, 16'd619, 16'd675, 16'd736, 16'd803, 16'd876, 16'd956, 16'd1042,
      16'd1137, 16'd1240, 16'd1352, 16'd1475, 16'd1609, 16'd1755, 16'd1914, 16'd2087,
      16'd2277, 16'd2483, 16'd2709, 16'd2954, 16'd3222, 16'd3515, 16'd3834, 16'd4182,
      16'd4561, 16'd4975, 16'd5426, 16'd5919, 16'd6456, 16'd7041, 16'd7680, 16'd8377,
      16'd9137, 16'd9966, 16'd10870, 16'd11857, 16'd12933, 16'd14106, 16'd15386,
      16'd16782, 16'd18305, 16'd19966, 16'd21778, 16'd23754, 16'd25909, 16'd28260,
      16'd30825, 16'd33622, 16'd36672, 16'd40000, 16'd43630, 16'd47589, 16'd51907,
      16'd56617, 16'd61754
   };

   // Reconstructed magnitude for each code from 44 upward.
   localparam logic [15:0] DEC_MAG [0:THR_COUNT-1] = '{
      16'd47, 16'd51, 16'd56, 16'd61, 16'd66, 16'd72, 16'd79, 16'd86, 16'd94, 16'd102,
      16'd112, 16'd122, 16'd133, 16'd145, 16'd158, 16'd173, 16'd189, 16'd206, 16'd225,
      16'd245, 16'd267, 16'd292, 16'd318, 16'd348, 16'd379, 16'd414, 16'd452, 16'd493,
      16'd538, 16'd587, 16'd640, 16'd699, 16'd763, 16'd832, 16'd908, 16'd991, 16'd1081,
      16'd1180, 16'd1288, 16'd1405, 16'd1534, 16'd1673, 16'd1826, 16'd1993, 16'd2175,
      16'd2373, 16'd2590, 16'd2826, 16'd3084, 16'd3365, 16'd3672, 16'd4008, 16'd4373,
      16'd4772, 16'd5208, 16'd5683, 16'd6202, 16'd6767, 16'd7385, 16'd8059, 16'd8794,
      16'd9597, 16'd10472, 16'd11428, 16'd12471, 16'd13609, 16'd14851, 16'd16206,
      16'd17685, 16'd19298, 16'd21060, 16'd22981, 16'd25078, 16'd27367, 16'd29864,
      16'd32589, 16'd35563, 16'd38808, 16'd42350, 16'd46214, 16'd50431, 16'd55033,
      16'd60055, 16'd65535
   };

   typedef struct packed {
      logic [7:0]  code;
      logic [15:0] next_pred;
      logic        error;
   } codec_result_type;

   // Magnitude code: direct below 44, else the last threshold reached.
   function automatic logic [7:0] enc_mag(input logic [15:0] n);
      logic [7:0] c;
      c = 8'(DIRECT_LIMIT - 1);
      for (int i = 0; i < THR_COUNT; i++) begin
         if (n >= ENC_THR[i]) begin
            c = 8'(DIRECT_LIMIT + i);
         end
      end
      if (n < 16'(DIRECT_LIMIT)) begin
         c = n[7:0];
      end
      return c;
   endfunction

   function automatic logic [15:0] mag_of(input logic [6:0] c);
      logic [15:0] m;
      if (c < 7'(DIRECT_LIMIT)) begin
         m = {9'd0, c};
      end else begin
         m = DEC_MAG[7'(c - 7'(DIRECT_LIMIT))];
      end
      return m;
   endfunction

   // Signed reconstruction step for an 8-bit code.
   function automatic logic signed [16:0] dec_val(input logic [7:0] v);
      logic signed [16:0] d;
      if (!v[7]) begin
         d = $signed({1'b0, mag_of(v[6:0])});
      end else if (v[6:0] == 7'd0) begin
         d = 17'sd1;
      end else begin
         d = -$signed({1'b0, mag_of(7'(8'd0 - v))});
      end
      return d;
   endfunction

endpackage

[design/ldae_codec.sv]
// Single-pass encoder datapath: delta, log code, overflow nudge, reconstruction
// and the deviation check for one sample. Depends on ldae_pkg.
`timescale 1ns / 1ps

module ldae_codec
   import ldae_pkg::*;
(
   input  logic [15:0]      sample,
   input  logic [15:0]      pred,
   output codec_result_type result
);

   logic signed [16:0] delta;
   logic signed [16:0] delta_abs;
   logic [7:0]         mag_code;
   logic [7:0]         code_raw;
   logic [7:0]         code_fix;
   logic signed [17:0] pred_x;
   logic signed [17:0] recon_raw;
   logic signed [17:0] recon_dn;
   logic signed [17:0] recon_up;
   logic signed [17:0] recon;
   logic signed [18:0] dev;
   logic               sample_pos;
   logic               over_hi;
   logic               over_lo;

   always_comb begin
      delta     = $signed({sample[15], sample}) - $signed({pred[15], pred});
      delta_abs = delta[16] ? -delta : delta;
      mag_code  = enc_mag(delta_abs[15:0]);
      code_raw  = delta[16] ? 8'(8'd0 - mag_code) : mag_code;

      // The neighbor codes are decoded in parallel so the nudge is only a select.
      pred_x    = 18'(signed'(pred));
      recon_raw = 18'(dec_val(code_raw)) + pred_x;
      recon_dn  = 18'(dec_val(8'(code_raw - 8'd1))) + pred_x;
      recon_up  = 18'(dec_val(8'(code_raw + 8'd1))) + pred_x;

      sample_pos = !sample[15] && (sample != 16'd0);
      over_hi    = recon_raw > 18'sd32767;
      over_lo    = recon_raw < -18'sd32768;

      if (sample_pos && over_hi) begin
         code_fix = 8'(code_raw - 8'd1);
         recon    = recon_dn;
      end else if (!sample_pos && over_lo) begin
         code_fix = 8'(code_raw + 8'd1);
         recon    = recon_up;
      end else begin
         code_fix = code_raw;
         recon    = recon_raw;
      end

      dev = 19'(recon) - 19'(signed'(sample));

      result.code      = code_fix;
      result.next_pred = recon[15:0];
      result.error     = (dev > 19'sd32767) || (dev < -19'sd32767);
   end

endmodule

[design/log_dpcm_audio_encoder.sv]
// Top level of the log-companded DPCM audio encoder: request register,
// encoder datapath, predictor state and response register. Depends on
// ldae_pkg and ldae_codec.
`timescale 1ns / 1ps

// Usage
// The request channel (req_valid, req_stall, req_sample, req_seed) takes one
// PCM sample per request. A seed request loads the current channel's
// predictor and is echoed raw on the response; a data request is coded into
// an 8-bit log DPCM code in the low bits of rsp_out_value. rsp_error flags a
// sample whose reconstruction would stray too far; its predictor and channel
// are left as they were. The response channel (rsp_valid, rsp_stall, ...)
// holds each response until it is taken.
// csr_valid/csr_ready/csr_num_channels write the channel count: 2 selects
// interleaved stereo (channels alternate 0, 1, 0, ...), any other value mono.
// Write it only while no request is in flight; csr_ready is always high.
// One request is accepted every cycle while the response is not stalled.
// The rate is set by the predictor feedback loop, which closes through the
// codec between the request register and the predictor registers. When the
// receiver stalls, the response register holds, the request register fills
// and then req_stall is raised until the response is taken. Synchronous
// reset empties both registers, clears both predictors and the channel,
// and selects mono.

module log_dpcm_audio_encoder
   import ldae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_sample,
   input  logic        req_seed,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_out_value,
   output logic        rsp_is_raw,
   output logic        rsp_error,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_num_channels
);

   logic             req_valid_ff;
   logic [15:0]      req_sample_ff;
   logic             req_seed_ff;

   logic             rsp_valid_ff;
   logic [15:0]      rsp_out_value_ff;
   logic             rsp_is_raw_ff;
   logic             rsp_error_ff;

   logic [15:0]      predictor_ff [2];
   logic             channel_ff;
   logic [1:0]       num_channels_ff;

   logic             stereo;
   logic             sel;
   logic             advance;
   logic             req_take;
   codec_result_type codec_res;

   // The held request moves to the response register when that is empty
   // or its content leaves in this same cycle.
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign stereo = (num_channels_ff == STEREO_CHANNELS);
   assign sel    = stereo ? channel_ff : 1'b0;

   ldae_codec u_codec (
      .sample (req_sample_ff),
      .pred   (predictor_ff[sel]),
      .result (codec_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (advance) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_sample_ff <= req_sample;
         req_seed_ff   <= req_seed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (req_seed_ff) begin
            rsp_out_value_ff <= req_sample_ff;
            rsp_is_raw_ff    <= 1'b1;
            rsp_error_ff     <= 1'b0;
         end else if (codec_res.error) begin
            rsp_out_value_ff <= 16'd0;
            rsp_is_raw_ff    <= 1'b0;
            rsp_error_ff     <= 1'b1;
         end else begin
            rsp_out_value_ff <= {8'd0, codec_res.code};
            rsp_is_raw_ff    <= 1'b0;
            rsp_error_ff     <= 1'b0;
         end
      end
   end

   // Predictor and channel move only for seeds and for data without error.
   always_ff @(posedge clock) begin
      if (reset) begin
         predictor_ff[0] <= 16'd0;
         predictor_ff[1] <= 16'd0;
         channel_ff      <= 1'b0;
      end else if (advance && (req_seed_ff || !codec_res.error)) begin
         predictor_ff[sel] <= req_seed_ff ? req_sample_ff : codec_res.next_pred;
         channel_ff        <= stereo ? !channel_ff : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_channels_ff <= 2'd1;
      end else if (csr_valid && csr_ready) begin
         num_channels_ff <= csr_num_channels;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_out_value_ff;
   assign rsp_is_raw    = rsp_is_raw_ff;
   assign rsp_error     = rsp_error_ff;

endmodule
